// File: hdl/radius2_cellular_automaton_core_macros.svh
// Assertion macros for the radius-2 cellular automaton core.
// Taken in by the modules that check their own logic; needs aclk and aresetn in scope.
`ifndef RADIUS2_CELLULAR_AUTOMATON_CORE_MACROS_SVH
`define RADIUS2_CELLULAR_AUTOMATON_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent holds in the same cycle as the antecedent.
`define R2CA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("r2ca: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define R2CA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("r2ca: next-cycle check failed");

`else

`define R2CA_ASSERT_SAME(lbl, ante, cons)
`define R2CA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/r2ca_pkg.sv
// Package for the radius-2 cellular automaton core: sizes, codes and state type.
// Depends on nothing; imported by radius2_cellular_automaton_core.
package r2ca_pkg;

    // Size of the cell row and derived widths.
    localparam int MAX_CELLS = 256;
    localparam int IDX_W     = $clog2(MAX_CELLS);
    localparam int WIDTH_W   = 9;
    localparam int MIN_WIDTH = 11;
    localparam int NBHD_W    = 5;
    localparam int RULE_W    = 1 << NBHD_W;

    // Stream payload widths.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_RULE_WORD    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_WIDTH = 2'd1;

    // Operation codes carried in s_tuser.
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_RUN   = 2'd2,
        FUNC_SEED  = 2'd3
    } func_t;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PASS = 3'b010,
        S_FIN  = 3'b100
    } state_t;

endpackage

// File: hdl/radius2_cellular_automaton_core.sv
// Radius-2 binary cellular automaton on a ring of configurable width.
// Depends on r2ca_pkg and radius2_cellular_automaton_core_macros.svh.
//
// Usage notes.
// Requests arrive on the s_ channel: s_tuser carries the operation (write cell,
// read cell, run generations, single seed) and s_tdata the position, the cell
// value and the generation count. Each request yields exactly one result on
// the m_ channel, with read_bit and done_res in m_tdata.
// The row lives in a 256-bit circular shift register that turns one cell per
// cycle while a pass is under way, past the rule lookups. Every operation but
// a run of zero generations is a bit-serial pass over all 256 cells, then the
// result is posted; a run takes one pass for each generation computed,
// stopping early once a generation leaves the row unchanged. One request is
// in work at a time; a new request is taken while the previous result still
// waits on m_tready. If the receiver stalls, the finished result is held in
// the output register and the sequencer waits before posting the next one.
// Reset (aresetn low, synchronous) clears every cell, sets rule_word to zero
// and active_width to 256. Registers must be written through cfg_wr_en only
// while idle, by the user; the core itself does not enforce this.

`include "radius2_cellular_automaton_core_macros.svh"

module radius2_cellular_automaton_core
    import r2ca_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Request channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // position[7:0], cell_value[8], generations[24:9]
    input  logic [S_TUSER_W-1:0]  s_tuser,  // func[1:0]
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // read_bit[0], done_res[1]
);

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_CELLS - 1);

    // Configuration registers.
    logic [RULE_W-1:0]    rule_reg;
    logic [WIDTH_W-1:0]   width_reg;

    // Cell row and sequencer.
    logic [MAX_CELLS-1:0] sr_reg, sr_next;
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     step_reg;
    func_t                func_reg;
    logic [7:0]           pos_reg;
    logic                 val_reg;
    logic [15:0]          gens_reg, gens_next;
    logic                 changed_reg, changed_next;
    logic                 rd_reg;

    // Saved old cells for the wrap-around of the ring.
    logic                 old_m1_reg, old_m2_reg;
    logic [3:0]           head_reg;
    logic                 new0_reg, new1_reg;

    // Output register.
    logic                 m_tvalid_reg;
    logic                 read_bit_reg;

    // Derived control values.
    logic [WIDTH_W-1:0]   w_eff;
    logic [IDX_W-1:0]     w_m1, w_m2, w_half;
    logic                 in_ring, at_pos, out_free, accept;
    logic [NBHD_W-1:0]    nbhd;
    logic                 new_bit, new0_c, new1_c, new0_sel, new1_sel;
    logic                 step_changed, pass_end, read_hit;

    // Width saturated into the legal range of the ring.
    always_comb begin
        if (width_reg < WIDTH_W'(MIN_WIDTH)) begin
            w_eff = WIDTH_W'(MIN_WIDTH);
        end else if (width_reg > WIDTH_W'(MAX_CELLS)) begin
            w_eff = WIDTH_W'(MAX_CELLS);
        end else begin
            w_eff = width_reg;
        end
    end

    assign w_m1   = IDX_W'(w_eff - WIDTH_W'(1));
    assign w_m2   = IDX_W'(w_eff - WIDTH_W'(2));
    assign w_half = IDX_W'(w_eff >> 1);

    assign in_ring  = WIDTH_W'(step_reg) < w_eff;
    assign at_pos   = WIDTH_W'(step_reg) == WIDTH_W'(pos_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pass_end = (state_reg == S_PASS) && (step_reg == LAST_STEP);
    assign read_hit = (state_reg == S_PASS) && (func_reg == FUNC_READ) && in_ring && at_pos;

    // Neighbourhood of the cell at the head; the right-hand cells wrap to the
    // saved old values of cells 0 and 1 near the end of the ring.
    always_comb begin
        nbhd[4] = old_m2_reg;
        nbhd[3] = old_m1_reg;
        nbhd[2] = sr_reg[0];
        nbhd[1] = (step_reg == w_m1) ? head_reg[0] : sr_reg[1];
        if (step_reg == w_m1) begin
            nbhd[0] = head_reg[1];
        end else if (step_reg == w_m2) begin
            nbhd[0] = head_reg[0];
        end else begin
            nbhd[0] = sr_reg[2];
        end
    end

    assign new_bit = rule_reg[nbhd];

    // Cells 0 and 1 need the old last two cells; they are worked out when the
    // last cell of the ring is at the head and written back at the pass end.
    assign new0_c   = rule_reg[{old_m1_reg, sr_reg[0], head_reg[0], head_reg[1], head_reg[2]}];
    assign new1_c   = rule_reg[{sr_reg[0], head_reg[0], head_reg[1], head_reg[2], head_reg[3]}];
    assign new0_sel = (step_reg == w_m1) ? new0_c : new0_reg;
    assign new1_sel = (step_reg == w_m1) ? new1_c : new1_reg;

    // Change detection for the early stop at a fixed point.
    always_comb begin
        step_changed = 1'b0;
        if (in_ring && (step_reg >= IDX_W'(2)) && (new_bit != sr_reg[0])) begin
            step_changed = 1'b1;
        end
        if ((step_reg == w_m1) && ((new0_c != head_reg[0]) || (new1_c != head_reg[1]))) begin
            step_changed = 1'b1;
        end
    end

    assign changed_next = changed_reg || step_changed;

    // Next value of the rotating row for each operation.
    always_comb begin
        sr_next = {sr_reg[0], sr_reg[MAX_CELLS-1:1]};
        case (func_reg)
            FUNC_WRITE: begin
                if (in_ring && at_pos) begin
                    sr_next[MAX_CELLS-1] = val_reg;
                end
            end
            FUNC_READ: begin
                sr_next = {sr_reg[0], sr_reg[MAX_CELLS-1:1]};
            end
            FUNC_RUN: begin
                if (in_ring && (step_reg >= IDX_W'(2))) begin
                    sr_next[MAX_CELLS-1] = new_bit;
                end
                if (step_reg == LAST_STEP) begin
                    sr_next[0] = new0_sel;
                    sr_next[1] = new1_sel;
                end
            end
            FUNC_SEED: begin
                if (in_ring) begin
                    sr_next[MAX_CELLS-1] = (step_reg == w_half);
                end
            end
            default: begin
                sr_next = {sr_reg[0], sr_reg[MAX_CELLS-1:1]};
            end
        endcase
    end

    // Sequencer transitions.
    always_comb begin
        state_next = state_reg;
        gens_next  = gens_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    gens_next = s_tdata[24:9];
                    if ((func_t'(s_tuser) == FUNC_RUN) && (s_tdata[24:9] == 16'd0)) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_PASS;
                    end
                end
            end
            S_PASS: begin
                if (pass_end) begin
                    if ((func_reg == FUNC_RUN) && (gens_reg != 16'd1) && changed_next) begin
                        gens_next = gens_reg - 16'd1;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_reg  <= '0;
            width_reg <= WIDTH_W'(MAX_CELLS);
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_RULE_WORD) begin
                rule_reg <= cfg_wdata[RULE_W-1:0];
            end else if (cfg_addr == REG_ACTIVE_WIDTH) begin
                width_reg <= cfg_wdata[WIDTH_W-1:0];
            end
        end
    end

    // Cell row, sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sr_reg       <= '0;
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            changed_reg  <= 1'b0;
            rd_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            gens_reg  <= gens_next;
            if (accept) begin
                rd_reg      <= 1'b0;
                changed_reg <= 1'b0;
            end
            if (state_reg == S_PASS) begin
                sr_reg     <= sr_next;
                step_reg   <= step_reg + IDX_W'(1);
                old_m1_reg <= sr_reg[0];
                old_m2_reg <= old_m1_reg;
                changed_reg <= pass_end ? 1'b0 : changed_next;
                if (step_reg == '0) begin
                    head_reg <= sr_reg[3:0];
                end
                if (step_reg == w_m1) begin
                    new0_reg <= new0_c;
                    new1_reg <= new1_c;
                end
                if (read_hit) begin
                    rd_reg <= sr_reg[0];
                end
            end
            if ((state_reg == S_FIN) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request fields and result payload; no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= func_t'(s_tuser);
            pos_reg  <= s_tdata[7:0];
            val_reg  <= s_tdata[8];
        end
        if ((state_reg == S_FIN) && out_free) begin
            read_bit_reg <= rd_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, 1'b1, read_bit_reg};

    // Self-checks on the sequencer.
    `R2CA_ASSERT_SAME(a_idle_step_zero, state_reg == S_IDLE, step_reg == '0)
    `R2CA_ASSERT_NEXT(a_out_only_from_fin, !m_tvalid_reg && (state_reg != S_FIN), !m_tvalid_reg)
    `R2CA_ASSERT_NEXT(a_fin_waits, (state_reg == S_FIN) && m_tvalid_reg && !m_tready, state_reg == S_FIN)
    `R2CA_ASSERT_SAME(a_read_only_on_read, (state_reg == S_FIN) && (func_reg != FUNC_READ), !rd_reg)

endmodule

// File: dv/radius2_cellular_automaton_core_tb.sv
`timescale 1ns / 1ps
// Testbench for radius2_cellular_automaton_core: directed and random requests checked
// against a scoreboard that tracks the cell row, the rule word and the ring width.
// Depends on r2ca_pkg and the core RTL only.

import r2ca_pkg::*;

// One result of the core, as unpacked from m_tdata.
typedef struct packed {
    logic done_res;
    logic read_bit;
} ca_result_t;

// Tracks the row and its settings, predicts each request's result and checks results in order.
class ca_row_scoreboard;
    logic [RULE_W-1:0]    rule_word;
    logic [WIDTH_W-1:0]   active_width;
    logic [MAX_CELLS-1:0] row;
    ca_result_t           awaited_results[$];
    int unsigned          error_count;

    function new();
        rule_word    = '0;
        active_width = WIDTH_W'(MAX_CELLS);
        row          = '0;
        error_count  = 0;
    endfunction

    // The ring width in use: the register saturated into the legal range.
    function int ring_width();
        int w;
        w = active_width;
        if (w < MIN_WIDTH) w = MIN_WIDTH;
        if (w > MAX_CELLS) w = MAX_CELLS;
        return w;
    endfunction

    function int outstanding();
        return awaited_results.size();
    endfunction

    // Writes to unknown indexes change nothing.
    function void note_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_RULE_WORD:    rule_word = value[RULE_W-1:0];
            REG_ACTIVE_WIDTH: active_width = value[WIDTH_W-1:0];
            default: ;
        endcase
    endfunction

    // One synchronous generation over cells 0..w-1; returns whether any cell changed.
    function bit evolve_row(int w);
        logic [MAX_CELLS-1:0] next_row;
        logic [NBHD_W-1:0]    nbhd;
        next_row = row;
        for (int c = 0; c < w; c++) begin
            nbhd = {row[(c + w - 2) % w], row[(c + w - 1) % w], row[c],
                    row[(c + 1) % w], row[(c + 2) % w]};
            next_row[c] = rule_word[nbhd];
        end
        evolve_row = (next_row != row);
        row = next_row;
    endfunction

    // Applies an accepted request to the row and queues the result it must produce.
    function void predict_request(func_t f, logic [IDX_W-1:0] pos, logic val,
                                  logic [15:0] gens);
        int         w;
        ca_result_t r;
        w          = ring_width();
        r.read_bit = 1'b0;
        r.done_res = 1'b1;
        case (f)
            FUNC_WRITE: begin
                if (pos < w) row[pos] = val;
            end
            FUNC_READ: begin
                if (pos < w) r.read_bit = row[pos];
            end
            FUNC_RUN: begin
                // A generation that changes nothing means the row has settled.
                for (int g = 0; g < gens; g++) begin
                    if (!evolve_row(w)) break;
                end
            end
            default: begin
                for (int c = 0; c < w; c++) row[c] = 1'b0;
                row[w / 2] = 1'b1;
            end
        endcase
        awaited_results.push_back(r);
    endfunction

    // Compares an accepted result with the oldest prediction.
    function void check_result(logic [M_TDATA_W-1:0] data);
        ca_result_t want;
        if (awaited_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("Result %h arrived with no request outstanding", data);
            return;
        end
        want = awaited_results.pop_front();
        if (data[0] !== want.read_bit || data[1] !== want.done_res) begin
            error_count++;
            if (error_count <= 10)
                $display("Result mismatch: expected read_bit %b done_res %b, got %b %b",
                         want.read_bit, want.done_res, data[0], data[1]);
        end
    endfunction
endclass

module radius2_cellular_automaton_core_tb;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int SETTLE_CYCLES   = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 240;
    localparam int MAX_SHORT_RUN   = 5;

    // Rules under which any row settles within two generations.
    localparam logic [RULE_W-1:0] RULE_ALL_ZERO = 32'h0000_0000;
    localparam logic [RULE_W-1:0] RULE_ALL_ONE  = 32'hFFFF_FFFF;
    localparam logic [RULE_W-1:0] RULE_IDENTITY = 32'hF0F0_F0F0;

    // Register indexes that the core does not decode.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // position[7:0], cell_value[8], generations[24:9]
    logic [S_TUSER_W-1:0]  s_tuser;   // func[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // read_bit[0], done_res[1]

    ca_row_scoreboard ledger;
    int unsigned      sender_idle_pct    = 0;
    int unsigned      receiver_stall_pct = 0;
    bit               hold_off_request   = 1'b0;
    bit               rule_settles       = 1'b1;
    int unsigned      quiet_cycles       = 0;

    radius2_cellular_automaton_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Receiver: random back-pressure, and one long hold-off when asked for.
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_request = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Result checking and the watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) ledger.check_result(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one request after a random gap and returns on the falling edge after it is taken.
    task automatic send_request(func_t f, logic [IDX_W-1:0] pos, logic val, logic [15:0] gens);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= S_TDATA_W'({gens, val, pos});
        do @(posedge aclk); while (!s_tready);
        ledger.predict_request(f, pos, val, gens);
        @(negedge aclk);
    endtask

    // Stops offering requests until every predicted result has been checked.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (ledger.outstanding() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        ledger.note_register(idx, value);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_rule(logic [RULE_W-1:0] rule);
        write_register(REG_RULE_WORD, rule);
        rule_settles = (rule == RULE_ALL_ZERO || rule == RULE_ALL_ONE || rule == RULE_IDENTITY);
    endtask

    // Long runs only where the row is known to settle quickly.
    function automatic logic [15:0] pick_generations();
        if (rule_settles && $urandom_range(3) == 0) return 16'($urandom);
        return 16'($urandom_range(MAX_SHORT_RUN));
    endfunction

    // Mostly inside the ring, sometimes anywhere.
    function automatic logic [IDX_W-1:0] pick_position();
        if ($urandom_range(6) == 0) return IDX_W'($urandom);
        return IDX_W'($urandom_range(ledger.ring_width() - 1));
    endfunction

    // Mostly pattern, evolve, read back; the rest is arbitrary noise.
    task automatic run_random_phase(int items);
        int    sent;
        int    burst;
        func_t f;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(40) == 0) drain_results();
            if ($urandom_range(6) == 0) begin
                f = func_t'($urandom_range(3));
                send_request(f, IDX_W'($urandom), 1'($urandom),
                             (f == FUNC_RUN) ? pick_generations() : 16'($urandom));
                sent++;
            end else begin
                if ($urandom_range(3) == 0) begin
                    send_request(FUNC_SEED, IDX_W'($urandom), 1'($urandom), 16'($urandom));
                    sent++;
                end else begin
                    burst = $urandom_range(1, 4);
                    repeat (burst)
                        send_request(FUNC_WRITE, pick_position(), 1'($urandom), 16'($urandom));
                    sent += burst;
                end
                send_request(FUNC_RUN, IDX_W'($urandom), 1'($urandom), pick_generations());
                burst = $urandom_range(2, 5);
                repeat (burst)
                    send_request(FUNC_READ, pick_position(), 1'($urandom), 16'($urandom));
                sent += burst + 1;
            end
        end
    endtask

    initial begin
        logic [RULE_W-1:0]     rule;
        logic [CFG_DATA_W-1:0] width;
        ledger    = new();
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_RULE_WORD;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_WRITE;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: rule zero, full ring. Edge positions, a zero-length run and a seed.
        send_request(FUNC_WRITE, 8'd255, 1'b1, 16'h0000);
        send_request(FUNC_WRITE, 8'd0, 1'b1, 16'hFFFF);
        send_request(FUNC_READ, 8'd255, 1'b0, 16'h0000);
        send_request(FUNC_READ, 8'd0, 1'b0, 16'h0000);
        send_request(FUNC_READ, 8'd7, 1'b0, 16'h0000);
        send_request(FUNC_RUN, 8'd0, 1'b0, 16'h0000);
        send_request(FUNC_READ, 8'd0, 1'b0, 16'h0000);
        send_request(FUNC_SEED, 8'd0, 1'b0, 16'h0000);
        send_request(FUNC_READ, 8'd128, 1'b0, 16'h0000);
        send_request(FUNC_READ, 8'd255, 1'b0, 16'h0000);
        send_request(FUNC_WRITE, 8'd200, 1'b1, 16'h0000);
        drain_results();

        // Width below range saturates to the smallest ring; spare indexes are ignored.
        set_rule(32'h6E9B_25D4);
        write_register(REG_ACTIVE_WIDTH, 32'd0);
        write_register(REG_SPARE_A, 32'hFFFF_FFFF);
        write_register(REG_SPARE_B, 32'h0000_0005);
        send_request(FUNC_WRITE, 8'd11, 1'b1, 16'h0000);
        send_request(FUNC_READ, 8'd11, 1'b0, 16'h0000);
        send_request(FUNC_SEED, 8'd0, 1'b0, 16'h0000);
        send_request(FUNC_RUN, 8'd0, 1'b0, 16'd4);
        send_request(FUNC_READ, 8'd5, 1'b0, 16'h0000);
        send_request(FUNC_READ, 8'd10, 1'b0, 16'h0000);
        drain_results();

        // Width above range with upper data bits set; cells beyond the old ring kept their values.
        set_rule(RULE_ALL_ONE);
        write_register(REG_ACTIVE_WIDTH, 32'hFFFF_FFFF);
        send_request(FUNC_READ, 8'd200, 1'b0, 16'h0000);
        send_request(FUNC_READ, 8'd255, 1'b0, 16'h0000);
        send_request(FUNC_RUN, 8'd0, 1'b1, 16'hFFFF);
        send_request(FUNC_READ, 8'd3, 1'b0, 16'h0000);
        send_request(FUNC_WRITE, 8'd3, 1'b0, 16'h0000);
        send_request(FUNC_READ, 8'd3, 1'b0, 16'h0000);

        // Random phases, each with its own rule, width and idling pattern.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            if (p % 3 == 2) begin
                case ($urandom_range(2))
                    0:       rule = RULE_ALL_ZERO;
                    1:       rule = RULE_ALL_ONE;
                    default: rule = RULE_IDENTITY;
                endcase
            end else begin
                rule = RULE_W'($urandom);
            end
            if (p == 0) begin
                width = MAX_CELLS;
            end else if (p == 1) begin
                width = MIN_WIDTH;
            end else if ($urandom_range(6) == 0) begin
                width = $urandom_range(MIN_WIDTH - 1);
            end else if ($urandom_range(6) == 0) begin
                width = $urandom_range(MAX_CELLS + 1, (1 << WIDTH_W) - 1);
            end else begin
                width = $urandom_range(MIN_WIDTH, MAX_CELLS);
            end
            set_rule(rule);
            write_register(REG_ACTIVE_WIDTH, width);
            case (p % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
                default: begin sender_idle_pct = 6;  receiver_stall_pct = 6;  end
            endcase
            // Hold the receiver off while requests keep coming, so the core backs up.
            if (p == 0) hold_off_request = 1'b1;
            run_random_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (ledger.error_count == 0 && ledger.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
